// ----- src/utd_pkg.sv -----
package utd_pkg;

  localparam int CpWidth = 31;
  localparam int LenWidth = 3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic                wide_form;
    logic [LenWidth-1:0] seq_bytes;
    logic [1:0]          status;
  } out_req_t;

  // Smallest value that a sequence of the given length may legally encode.
  function automatic logic [CpWidth-1:0] min_value(input logic [LenWidth-1:0] len);
    logic [CpWidth-1:0] v;
    case (len)
      3'd2:    v = 31'h0000080;
      3'd3:    v = 31'h0000800;
      3'd4:    v = 31'h0010000;
      3'd5:    v = 31'h0200000;
      3'd6:    v = 31'h4000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/utd_core.sv -----
module utd_core
  import utd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_req_t  req,
  output logic     res_valid,
  output out_req_t res
);

  logic [CpWidth-1:0]  partial_r, partial_nxt;
  logic [LenWidth-1:0] expected_r, expected_nxt;
  logic [LenWidth-1:0] seen_r, seen_nxt;

  logic                seq_open;
  logic [LenWidth-1:0] seen_now;
  logic [CpWidth-1:0]  shifted;
  logic [LenWidth-1:0] lead_len;
  logic [CpWidth-1:0]  lead_bits;
  logic                lead_ok;
  logic [7:0]          b;

  assign b = req.data_byte;
  assign seq_open = (expected_r >= 3'd2) && (expected_r <= 3'd6) &&
                    (seen_r != '0) && (seen_r < expected_r);
  assign seen_now = seen_r + 3'd1;
  assign shifted = {partial_r[CpWidth-7:0], b[5:0]};

  always_comb begin
    lead_ok = 1'b1;
    lead_len = '0;
    lead_bits = '0;
    case (b) inside
      8'b110?????: begin
        lead_len = 3'd2;
        lead_bits = {26'd0, b[4:0]};
      end
      8'b1110????: begin
        lead_len = 3'd3;
        lead_bits = {27'd0, b[3:0]};
      end
      8'b11110???: begin
        lead_len = 3'd4;
        lead_bits = {28'd0, b[2:0]};
      end
      8'b111110??: begin
        lead_len = 3'd5;
        lead_bits = {29'd0, b[1:0]};
      end
      8'b1111110?: begin
        lead_len = 3'd6;
        lead_bits = {30'd0, b[0]};
      end
      default: lead_ok = 1'b0;
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res = '0;
    partial_nxt = partial_r;
    expected_nxt = expected_r;
    seen_nxt = seen_r;
    if (accept) begin
      partial_nxt = '0;
      expected_nxt = '0;
      seen_nxt = '0;
      if (!seq_open) begin
        res.seq_bytes = 3'd1;
        if (b[7:6] == 2'b10) begin
          res_valid = 1'b1;
          res.status = ST_ILLEGAL;
        end else if (!b[7]) begin
          res_valid = 1'b1;
          res.status = ST_OK;
          res.code_point = {23'd0, b};
        end else if (!lead_ok) begin
          res_valid = 1'b1;
          res.status = ST_ILLEGAL;
        end else if (req.end_of_stream) begin
          res_valid = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          partial_nxt = lead_bits;
          expected_nxt = lead_len;
          seen_nxt = 3'd1;
        end
      end else begin
        res.seq_bytes = seen_now;
        if (req.end_of_stream && (seen_now < expected_r)) begin
          res_valid = 1'b1;
          res.status = ST_TRUNC;
        end else if (!b[7]) begin
          res_valid = 1'b1;
          res.status = ST_ILLEGAL;
        end else if (seen_now == expected_r) begin
          res_valid = 1'b1;
          if (shifted < min_value(expected_r)) begin
            res.status = ST_ILLEGAL;
          end else begin
            res.status = ST_OK;
            res.code_point = shifted;
            res.wide_form = 1'b1;
          end
        end else begin
          partial_nxt = shifted;
          expected_nxt = expected_r;
          seen_nxt = seen_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      expected_r <= '0;
      seen_r <= '0;
    end else begin
      partial_r <= partial_nxt;
      expected_r <= expected_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- src/utf8_to_ucs4_decoder.sv -----
// UTF-8 to UCS-4 decoder, one byte of the stream per input request.
// Input channel: in_valid / in_ready carry in_data, a raw byte and a flag that
// marks the last byte of the stream. Output channel: out_valid / out_ready
// carry out_data, a code point with its class, byte count and status.
// A request that completes a character, or ends a sequence with an error,
// yields one result; lead and middle bytes of a sequence yield none.
// The result is registered: it enters the output register when the request that
// completes it is accepted, or the skid register while the output stalls.
// Throughput is one byte per cycle while in_ready is high, set by the single
// decode stage between the sequence state and the output register.
// The output register is backed by a one-entry skid register, so the decoder
// keeps accepting while a result waits. When the receiver stalls long enough
// for both to fill, in_ready drops until the output register drains.
// Reset (rst_n low, synchronous) closes any open sequence and empties both
// result registers.
module utf8_to_ucs4_decoder
  import utd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  logic     accept;
  logic     res_valid;
  out_req_t res;

  logic     out_valid_r, out_valid_nxt;
  out_req_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  out_req_t skid_data_r, skid_data_nxt;

  assign in_ready = !skid_valid_r;
  assign accept = in_valid && in_ready;

  utd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid register holds a result while the output register is empty.");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("A result arrived under a stalled output and was not kept.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |->
      ((out_data.code_point == '0) && !out_data.wide_form))
    else $error("An error result carries a nonzero value or class.");

  a_wide_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.wide_form) |->
      ((out_data.seq_bytes >= 3'd2) && (out_data.seq_bytes <= 3'd6)))
    else $error("A wide result has an impossible sequence length.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == ST_OK) || (out_data.status == ST_ILLEGAL) ||
                   (out_data.status == ST_TRUNC)))
    else $error("A result carries an undefined status.");

endmodule

// ----- tb/sv/utf8_to_ucs4_decoder_tb.sv -----
module utf8_to_ucs4_decoder_tb;
  import utd_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;

  utf8_to_ucs4_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sequence state of the decoder as predicted from the accepted bytes.
  logic [CpWidth-1:0]  open_cp = '0;
  logic [LenWidth-1:0] open_len = '0;
  logic [LenWidth-1:0] open_seen = '0;

  out_req_t    pending_chars[$];
  out_req_t    oldest_char;
  int unsigned bytes_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned wide_count = 0;
  int unsigned illegal_count = 0;
  int unsigned trunc_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("utf8_to_ucs4_decoder_tb: done, errors");
    $finish;
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) :
                                         $urandom_range(12, 40);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output out_req_t r);
    logic [LenWidth-1:0] seen_next;
    logic [CpWidth-1:0]  floor_cp;
    r = '0;
    if (open_len == 0 || open_seen >= open_len) begin
      open_cp = '0;
      open_len = '0;
      open_seen = '0;
      r.seq_bytes = 3'd1;
      if (b[7:6] == 2'b10) begin
        r.status = ST_ILLEGAL;
        return 1'b1;
      end
      if (!b[7]) begin
        r.code_point = {23'b0, b};
        r.status = ST_OK;
        return 1'b1;
      end
      case (b) inside
        8'b110?????: begin
          open_len = 3'd2;
          open_cp = {26'b0, b[4:0]};
        end
        8'b1110????: begin
          open_len = 3'd3;
          open_cp = {27'b0, b[3:0]};
        end
        8'b11110???: begin
          open_len = 3'd4;
          open_cp = {28'b0, b[2:0]};
        end
        8'b111110??: begin
          open_len = 3'd5;
          open_cp = {29'b0, b[1:0]};
        end
        8'b1111110?: begin
          open_len = 3'd6;
          open_cp = {30'b0, b[0]};
        end
        default: begin
          r.status = ST_ILLEGAL;
          return 1'b1;
        end
      endcase
      if (eos) begin
        open_cp = '0;
        open_len = '0;
        r.status = ST_TRUNC;
        return 1'b1;
      end
      open_seen = 3'd1;
      return 1'b0;
    end
    seen_next = open_seen + 3'd1;
    r.seq_bytes = seen_next;
    if ((eos && seen_next < open_len) || !b[7]) begin
      r.status = (!b[7] && !(eos && seen_next < open_len)) ? ST_ILLEGAL : ST_TRUNC;
      open_cp = '0;
      open_len = '0;
      open_seen = '0;
      return 1'b1;
    end
    open_cp = {open_cp[CpWidth-7:0], b[5:0]};
    open_seen = seen_next;
    if (seen_next != open_len) return 1'b0;
    case (open_len)
      3'd2:    floor_cp = 31'h0000080;
      3'd3:    floor_cp = 31'h0000800;
      3'd4:    floor_cp = 31'h0010000;
      3'd5:    floor_cp = 31'h0200000;
      default: floor_cp = 31'h4000000;
    endcase
    if (open_cp < floor_cp) begin
      r.status = ST_ILLEGAL;
    end else begin
      r.code_point = open_cp;
      r.wide_form = 1'b1;
      r.status = ST_OK;
    end
    open_cp = '0;
    open_len = '0;
    open_seen = '0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    out_req_t r;
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (decode_byte(b, eos, r)) pending_chars.push_back(r);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Sends the first cnt bytes of the n-byte encoding of v.
  task automatic send_seq(input int unsigned n, input logic [30:0] v,
                          input int unsigned cnt, input bit eos_last);
    logic [31:0] prefix;
    logic [31:0] bits;
    logic [7:0]  b;
    for (int unsigned k = 0; k < cnt; k++) begin
      if (n == 1) begin
        b = {1'b0, v[6:0]};
      end else if (k == 0) begin
        prefix = 32'hFF << (8 - n);
        bits = ({1'b0, v} >> (6 * (n - 1))) & ((32'd1 << (7 - n)) - 1);
        b = prefix[7:0] | bits[7:0];
      end else begin
        bits = ({1'b0, v} >> (6 * (n - 1 - k))) & 32'h3F;
        b = 8'h80 | bits[7:0];
        if ($urandom_range(0, 19) == 0) b = b | 8'h40;
      end
      send_byte(b, eos_last && k == cnt - 1);
    end
  endtask

  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %p", out_data);
      end else begin
        oldest_char = pending_chars.pop_front();
        chars_checked++;
        if (oldest_char.wide_form) wide_count++;
        if (oldest_char.status == ST_ILLEGAL) illegal_count++;
        if (oldest_char.status == ST_TRUNC) trunc_count++;
        if (out_data.code_point !== oldest_char.code_point ||
            out_data.wide_form !== oldest_char.wide_form ||
            out_data.seq_bytes !== oldest_char.seq_bytes ||
            out_data.status !== oldest_char.status) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected cp=%h wide=%b n=%0d st=%0d,",
                     oldest_char.code_point, oldest_char.wide_form,
                     oldest_char.seq_bytes, oldest_char.status);
            $display("          got cp=%h wide=%b n=%0d st=%0d",
                     out_data.code_point, out_data.wide_form,
                     out_data.seq_bytes, out_data.status);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_sequences();
    send_seq(2, 31'h80, 2, 1'b0);
    send_seq(6, 31'h7FFFFFFF, 6, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_sequence_errors();
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 60;
    for (int unsigned k = 0; k < 30; k++) send_byte(8'h20 + k[7:0], 1'b0);
    for (int unsigned k = 0; k < 5; k++) begin
      send_seq(3, 31'($urandom_range(16'h800, 16'hFFFF)), 3, 1'b0);
    end
    drain_results();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_pause_between_bursts();
    for (int unsigned k = 0; k < 4; k++) begin
      for (int unsigned j = 0; j < 8; j++) begin
        send_seq(j % 6 + 1, 31'($urandom()), j % 6 + 1, 1'b0);
      end
      drain_results();
    end
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned cnt;
    int unsigned width;
    logic [31:0] raw;
    logic [30:0] v;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 49) == 0) begin
        tx_gaps_on = $urandom_range(0, 2) != 0;
        rx_stalls_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 6);
      width = (len == 1) ? 7 : 5 * len + 1;
      raw = $urandom() & ((width == 32) ? 32'hFFFFFFFF : (32'd1 << width) - 1);
      if ($urandom_range(0, 7) == 0) raw = raw >> $urandom_range(0, width);
      v = raw[30:0];
      if (pick < 80) begin
        send_seq(len, v, len, $urandom_range(0, 49) == 0);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        len = $urandom_range(2, 6);
        cnt = $urandom_range(1, len - 1);
        send_seq(len, v, cnt, 1'b0);
        if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(0, 127)), 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bytes();
    test_sequences();
    test_sequence_errors();
    drain_results();
    test_output_backpressure();
    test_pause_between_bursts();
    test_random_stream(1800);
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes covering ASCII, one- to six-byte forms, stray and invalid bytes,",
             bytes_sent);
    $display("overlong and cut-off sequences: %0d results checked, %0d wide,",
             chars_checked, wide_count);
    $display("%0d illegal, %0d truncated.", illegal_count, trunc_count);
    if (fail_count == 0) begin
      $display("utf8_to_ucs4_decoder_tb: done, clean");
    end else begin
      $display("utf8_to_ucs4_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/utd_pkg.sv
src/utd_core.sv
src/utf8_to_ucs4_decoder.sv
tb/sv/utf8_to_ucs4_decoder_tb.sv
